// ----- rtl/core/glt_pkg.sv -----
package glt_pkg;

    localparam int GRID_DIM   = 64;
    localparam int COORD_W    = 6;
    localparam int ERR_W      = 10;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_DIM - 1);

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic signed [ERR_W-1:0] t_err;

    // one line walk, as handed from classifier to walker
    typedef struct packed {
        logic   row_is_major;
        logic   step_neg;
        logic   skip_first;
        t_coord a_start;
        t_coord b_start;
        t_coord a_last;
        t_coord dmaj;
        t_coord dmin;
        t_err   err;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

    function automatic t_coord clamp_coord(input t_coord v);
        clamp_coord = (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    function automatic t_coord abs_diff(input t_coord x, input t_coord y);
        abs_diff = (x >= y) ? (x - y) : (y - x);
    endfunction

endpackage

// ----- rtl/core/glt_front.sv -----
module glt_front (
    input  logic                            i_valid,
    input  logic [glt_pkg::IN_DATA_W-1:0]   i_data,
    output glt_pkg::t_job_req               o_req
);

    glt_pkg::t_coord sr, sc, er, ec;
    glt_pkg::t_coord d_row, d_col;
    glt_pkg::t_coord a0, b0, a1, b1;
    glt_pkg::t_coord s_a0, s_b0, s_a1, s_b1;
    glt_pkg::t_coord dmaj, dmin;
    logic            rmaj, sw, neg;

    always_comb begin
        sr = glt_pkg::clamp_coord(i_data[5:0]);
        sc = glt_pkg::clamp_coord(i_data[11:6]);
        er = glt_pkg::clamp_coord(i_data[17:12]);
        ec = glt_pkg::clamp_coord(i_data[23:18]);

        d_row = glt_pkg::abs_diff(er, sr);
        d_col = glt_pkg::abs_diff(ec, sc);
        rmaj  = d_col < d_row;

        a0 = rmaj ? sr : sc;
        b0 = rmaj ? sc : sr;
        a1 = rmaj ? er : ec;
        b1 = rmaj ? ec : er;

        sw   = a0 > a1;
        s_a0 = sw ? a1 : a0;
        s_b0 = sw ? b1 : b0;
        s_a1 = sw ? a0 : a1;
        s_b1 = sw ? b0 : b1;

        dmaj = s_a1 - s_a0;
        neg  = s_b1 < s_b0;
        dmin = neg ? (s_b0 - s_b1) : (s_b1 - s_b0);

        o_req.job.row_is_major = rmaj;
        o_req.job.step_neg     = neg;
        o_req.job.skip_first   = !sw;
        o_req.job.a_start      = s_a0;
        o_req.job.b_start      = s_b0;
        // swapped walks drop the final point instead of the first
        o_req.job.a_last       = sw ? (s_a1 - glt_pkg::COORD_W'(1)) : s_a1;
        o_req.job.dmaj         = dmaj;
        o_req.job.dmin         = dmin;
        o_req.job.err          = $signed({3'b000, dmin, 1'b0})
                               - $signed({4'b0000, dmaj});
        // zero-length line gives nothing
        o_req.valid            = i_valid && (dmaj != '0);
    end

endmodule

// ----- rtl/core/glt_queue.sv -----
module glt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  glt_pkg::t_job_req i_push,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output glt_pkg::t_job     o_job
);

    glt_pkg::t_job                  r_mem [glt_pkg::Q_DEPTH];
    logic [glt_pkg::Q_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [glt_pkg::Q_CNT_W-1:0]    r_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == glt_pkg::Q_CNT_W'(glt_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + glt_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + glt_pkg::Q_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + glt_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - glt_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/glt_walk.sv -----
module glt_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  glt_pkg::t_job                   i_job,
    output logic                            o_job_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [glt_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                            o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SKIP,
        S_RUN
    } t_state;

    t_state          r_state;
    logic            r_row_is_major, r_step_neg;
    glt_pkg::t_coord r_a, r_b, r_a_last, r_dmaj, r_dmin;
    glt_pkg::t_err   r_err;

    glt_pkg::t_coord n_a, n_b;
    glt_pkg::t_err   n_err;
    logic            step_en, at_last;

    always_comb begin
        step_en   = !o_valid || i_ready;
        at_last   = (r_a == r_a_last);
        o_job_pop = (r_state == S_IDLE) && i_job_valid;
        n_a       = r_a + glt_pkg::COORD_W'(1);
        if (r_err > 0) begin
            n_b   = r_step_neg ? (r_b - glt_pkg::COORD_W'(1)) : (r_b + glt_pkg::COORD_W'(1));
            n_err = r_err + $signed({3'b000, r_dmin, 1'b0}) - $signed({3'b000, r_dmaj, 1'b0});
        end else begin
            n_b   = r_b;
            n_err = r_err + $signed({3'b000, r_dmin, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_row_is_major <= i_job.row_is_major;
                        r_step_neg     <= i_job.step_neg;
                        r_a            <= i_job.a_start;
                        r_b            <= i_job.b_start;
                        r_a_last       <= i_job.a_last;
                        r_dmaj         <= i_job.dmaj;
                        r_dmin         <= i_job.dmin;
                        r_err          <= i_job.err;
                        r_state        <= i_job.skip_first ? S_SKIP : S_RUN;
                    end
                end
                S_SKIP: begin
                    r_a     <= n_a;
                    r_b     <= n_b;
                    r_err   <= n_err;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (step_en) begin
                        o_valid <= 1'b1;
                        o_last  <= at_last;
                        o_data  <= r_row_is_major ? {4'b0000, r_b, r_a} : {4'b0000, r_a, r_b};
                        r_a     <= n_a;
                        r_b     <= n_b;
                        r_err   <= n_err;
                        if (at_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/grid_line_tile_generator.sv -----
// Channel  Dir  Width  Contents
// s_axis   in   24     start_row, start_col, end_row, end_col (from bit 0)
// m_axis   out  16     row, col (from bit 0), zero pad; tlast on final tile
//
// A line of major span N gives N tiles, one per cycle while m_axis is ready.
// The walker takes each job in its idle state and passes through a skip
// state when the first point of the line is dropped.
// A two-entry job queue lets s_axis keep accepting while a line is walked.
// Synchronous active-low reset clears the queue and walker control.
module grid_line_tile_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [glt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // start_row, start_col, end_row, end_col
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [glt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // row, col, pad
    output logic                            m_axis_tlast
);

    glt_pkg::t_job_req front_req, push_req;
    glt_pkg::t_job     head_job;
    logic              q_full, q_valid, q_pop;

    glt_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_req   (front_req)
    );

    assign s_axis_tready = !q_full;

    always_comb begin
        push_req       = front_req;
        push_req.valid = front_req.valid && s_axis_tready;
    end

    glt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    glt_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
